// ----- hdl/zvd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Zarith varint decoder package
// Shared transaction types and constants for the varint decoder.
// ----------------------------------------------------------------------------
package zvd_pkg;

  localparam int unsigned WordW = 64;

  localparam logic [7:0] ValMask6 = 8'h3F;
  localparam logic [7:0] ValMask7 = 8'h7F;

  typedef enum logic [1:0] {
    ST_CONT = 2'd0,
    ST_DONE = 2'd1,
    ST_ERR  = 2'd2
  } status_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       unsigned_mode;
  } in_t;

  typedef struct packed {
    status_e    status;
    logic [63:0] value_word;
    logic [1:0] word_index;
    logic       negative;
    logic [8:0] bit_length;
    logic       last;
  } out_t;

endpackage

// ----- hdl/zarith_varint_decoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Zarith varint decoder
// Decodes signed or natural little-endian base-128 integers one byte at a
// time and returns the magnitude as 64-bit words with sign and bit length.
// ----------------------------------------------------------------------------
// The block takes one byte per cycle through an input register while it is not
// stalled, and answers every byte from an output register loaded from the input
// register. A continuation byte and a too-large error each produce one
// transaction; a terminating byte produces ceil(bit_length/64) word
// transactions, at least one, and the input holds off while the words beyond
// the first are pending.
module zarith_varint_decoder #(
  parameter int unsigned NUM_BITS = 256
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  zvd_pkg::in_t   in_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output zvd_pkg::out_t  out_o
);
  import zvd_pkg::*;

  localparam int unsigned Nbytes = NUM_BITS / 8;
  localparam int unsigned NbW    = Nbytes * 8;
  localparam int unsigned Nwords = (NUM_BITS + 63) / 64;
  localparam int unsigned NwW    = Nwords * WordW;
  localparam int unsigned CntW   = $clog2(NUM_BITS + 1);
  localparam int unsigned LoW    = CntW - 3;
  localparam int unsigned WidxW  = (Nwords > 1) ? $clog2(Nwords) : 1;
  localparam int unsigned LenW   = (CntW > 9) ? CntW : 9;
  localparam int unsigned WiW    = (WidxW > 2) ? WidxW : 2;

  logic              in_valid_q;
  in_t               in_q;

  logic [NbW-1:0]    mag_q;
  logic [CntW-1:0]   count_q;
  logic              sign_q;

  logic              out_valid_q;
  status_e           status_q;
  logic [NwW-1:0]    buf_q;
  logic [WidxW-1:0]  wcnt_q;
  logic [WidxW-1:0]  last_idx_q;
  logic              neg_q;
  logic [CntW-1:0]   len_q;

  logic              cont;
  logic              signed_first;
  logic [6:0]        v;
  logic [2:0]        s;
  logic [15:0]       shifted;
  logic [7:0]        lo_byte;
  logic [7:0]        hi_byte;
  logic [LoW-1:0]    lo_idx;
  logic              at_end;
  logic              err;
  logic              done;
  logic [NbW-1:0]    mag_next;
  logic [CntW-1:0]   count_next;
  logic [CntW-1:0]   cnt_m1;
  logic              sign_next;

  logic              out_last;
  logic              out_pop;
  logic              out_free;
  logic              advance;
  logic [LenW-1:0]   len_ext;
  logic [WiW-1:0]    widx_ext;

  assign cont         = in_q.in_byte[7];
  assign signed_first = (count_q == '0) && !in_q.unsigned_mode;
  assign v            = signed_first ? (in_q.in_byte[6:0] & ValMask6[6:0])
                                     : (in_q.in_byte[6:0] & ValMask7[6:0]);
  assign s            = signed_first ? 3'd6 : 3'd7;
  assign shifted      = {9'b0, v} << count_q[2:0];
  assign lo_byte      = shifted[7:0];
  assign hi_byte      = shifted[15:8];
  assign lo_idx       = count_q[CntW-1:3];
  assign at_end       = (lo_idx == LoW'(Nbytes - 1));
  assign err          = at_end && ((hi_byte != 8'd0) || cont);
  assign done         = !cont && !err;
  assign sign_next    = signed_first ? in_q.in_byte[6] : sign_q;
  assign count_next   = at_end ? CntW'(NUM_BITS) : (count_q + {{(CntW - 3){1'b0}}, s});
  assign cnt_m1       = count_next - CntW'(1);

  always_comb begin
    for (int i = 0; i < int'(Nbytes); i++) begin
      mag_next[i*8 +: 8] = mag_q[i*8 +: 8];
      if (lo_idx == LoW'(i)) begin
        mag_next[i*8 +: 8] = mag_q[i*8 +: 8] | lo_byte;
      end
      if ((i > 0) && (lo_idx == LoW'(i - 1))) begin
        mag_next[i*8 +: 8] = mag_q[i*8 +: 8] | hi_byte;
      end
    end
  end

  assign out_last   = (status_q != ST_DONE) || (wcnt_q == last_idx_q);
  assign out_pop    = out_valid_q && !out_stall_i;
  assign out_free   = !out_valid_q || (out_pop && out_last);
  assign advance    = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mag_q   <= '0;
      count_q <= '0;
      sign_q  <= 1'b0;
    end else if (advance) begin
      if (cont && !err) begin
        mag_q   <= mag_next;
        count_q <= count_next;
        sign_q  <= sign_next;
      end else begin
        mag_q   <= '0;
        count_q <= '0;
        sign_q  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      status_q    <= ST_CONT;
      wcnt_q      <= '0;
      last_idx_q  <= '0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
      wcnt_q      <= '0;
      if (err) begin
        status_q   <= ST_ERR;
        last_idx_q <= '0;
      end else if (cont) begin
        status_q   <= ST_CONT;
        last_idx_q <= '0;
      end else begin
        status_q   <= ST_DONE;
        last_idx_q <= WidxW'(cnt_m1 >> 6);
      end
    end else if (out_pop) begin
      if (out_last) begin
        out_valid_q <= 1'b0;
      end else begin
        wcnt_q <= wcnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      buf_q <= NwW'(mag_next);
      neg_q <= done ? sign_next : 1'b0;
      len_q <= done ? count_next : '0;
    end else if (out_pop && !out_last) begin
      buf_q <= buf_q >> WordW;
    end
  end

  assign len_ext  = LenW'(len_q);
  assign widx_ext = WiW'(wcnt_q);

  always_comb begin
    out_o.status     = status_q;
    out_o.value_word = (status_q == ST_DONE) ? buf_q[WordW-1:0] : '0;
    out_o.word_index = widx_ext[1:0];
    out_o.negative   = neg_q;
    out_o.bit_length = len_ext[8:0];
    out_o.last       = out_last;
  end

  assign out_valid_o = out_valid_q;

  property p_err_clears;
    @(posedge clk_i) disable iff (!rst_ni)
      advance && err |=> (count_q == '0) && (mag_q == '0) && !sign_q;
  endproperty
  a_err_clears: assert property (p_err_clears)
    else $error("State not cleared after a too-large error.");

  property p_count_below_max;
    @(posedge clk_i) disable iff (!rst_ni)
      count_q < CntW'(NUM_BITS);
  endproperty
  a_count_below_max: assert property (p_count_below_max)
    else $error("Held bit count reached the buffer size.");

  property p_hold_during_words;
    @(posedge clk_i) disable iff (!rst_ni)
      out_valid_q && !out_last |-> !advance;
  endproperty
  a_hold_during_words: assert property (p_hold_during_words)
    else $error("New byte taken while words of a number are still pending.");

  property p_word_index_bound;
    @(posedge clk_i) disable iff (!rst_ni)
      out_valid_q |-> (wcnt_q <= last_idx_q);
  endproperty
  a_word_index_bound: assert property (p_word_index_bound)
    else $error("Word counter ran past the final word.");

endmodule

// ----- sim/zarith_varint_decoder_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Zarith varint decoder testbench
// Sends varint bytes in signed and natural mode through the valid/stall input
// and checks every response transaction against a cycle-free decoder written
// in the bench. Covers short numbers, multi-word numbers, the end of the
// magnitude buffer, random traffic with both sides idling, and a long output
// hold-off that fills the block.
// ----------------------------------------------------------------------------
module zarith_varint_decoder_tb;
  import zvd_pkg::*;

  localparam int unsigned NumBits  = 256;
  localparam int unsigned NumBytes = NumBits / 8;

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  logic in_stall_o;
  in_t  in_i        = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_t out_o;

  logic [7:0]  magnitude_acc [NumBytes];
  int unsigned bit_count;
  logic        sign_bit;
  out_t        varint_responses [$];

  int unsigned send_gap_pct = 0;
  int unsigned rx_stall_pct = 0;
  logic        hold_rx      = 1'b0;
  int unsigned bytes_sent   = 0;
  int unsigned mismatches   = 0;

  zarith_varint_decoder #(
    .NUM_BITS(NumBits)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_i       (in_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_o      (out_o)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  function automatic void clear_accumulator();
    for (int i = 0; i < NumBytes; i++) magnitude_acc[i] = 8'h00;
    bit_count = 0;
    sign_bit  = 1'b0;
  endfunction

  function automatic void decode_varint_byte(input in_t item);
    logic        cont;
    logic [7:0]  v;
    logic [15:0] spread;
    int unsigned width;
    int unsigned lo_idx;
    int unsigned nwords;
    out_t        resp;
    cont = item.in_byte[7];
    if (bit_count >= NumBits) bit_count = 0;
    if (bit_count == 0 && !item.unsigned_mode) begin
      v        = item.in_byte & ValMask6;
      sign_bit = item.in_byte[6];
      width    = 6;
    end else begin
      v     = item.in_byte & ValMask7;
      width = 7;
    end
    spread = {8'h00, v} << (bit_count % 8);
    lo_idx = bit_count / 8;
    resp   = '0;
    if (lo_idx < NumBytes) magnitude_acc[lo_idx] |= spread[7:0];
    if (lo_idx + 1 >= NumBytes) begin
      if (spread[15:8] != 8'h00 || cont) begin
        clear_accumulator();
        resp.status = ST_ERR;
        resp.last   = 1'b1;
        varint_responses.push_back(resp);
        return;
      end
      bit_count = NumBits;
    end else begin
      magnitude_acc[lo_idx + 1] = spread[15:8];
      bit_count += width;
    end
    if (cont) begin
      resp.status = ST_CONT;
      resp.last   = 1'b1;
      varint_responses.push_back(resp);
      return;
    end
    nwords = (bit_count + 63) / 64;
    if (nwords == 0) nwords = 1;
    for (int k = 0; k < nwords; k++) begin
      resp.status     = ST_DONE;
      for (int j = 0; j < 8; j++) resp.value_word[8*j +: 8] = magnitude_acc[8*k + j];
      resp.word_index = k[1:0];
      resp.negative   = sign_bit;
      resp.bit_length = bit_count[8:0];
      resp.last       = (k + 1 == nwords);
      varint_responses.push_back(resp);
    end
    clear_accumulator();
  endfunction

  task automatic compare_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  task automatic check_response(input out_t got);
    out_t want;
    if (varint_responses.size() == 0) begin
      mismatches++;
      $display("%0t: unexpected transaction, expected none, actual %h", $time, got);
      return;
    end
    want = varint_responses.pop_front();
    compare_field("status", want.status, got.status);
    compare_field("value_word", want.value_word, got.value_word);
    compare_field("word_index", want.word_index, got.word_index);
    compare_field("negative", want.negative, got.negative);
    compare_field("bit_length", want.bit_length, got.bit_length);
    compare_field("last", want.last, got.last);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) check_response(out_o);
    out_stall_i <= hold_rx || ($urandom_range(99) < rx_stall_pct);
  end

  task automatic send_byte(input logic [7:0] data, input logic mode);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i            <= 1'b1;
    in_i.in_byte          <= data;
    in_i.unsigned_mode    <= mode;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    decode_varint_byte('{in_byte: data, unsigned_mode: mode});
    bytes_sent++;
  endtask

  task automatic send_repeated(input logic [7:0] data, input logic mode, input int n);
    repeat (n) send_byte(data, mode);
  endtask

  task automatic stop_input();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_for_responses();
    while (varint_responses.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_random_number();
    int unsigned len;
    logic        mode;
    logic [7:0]  data;
    len  = ($urandom_range(9) == 0) ? $urandom_range(30, 38) : $urandom_range(1, 6);
    mode = 1'($urandom_range(1));
    for (int i = 0; i < len; i++) begin
      data    = 8'($urandom_range(255));
      data[7] = (i != len - 1);
      send_byte(data, (i == 0) ? mode : logic'($urandom_range(1)));
    end
  endtask

  task automatic test_directed_values();
    send_gap_pct = 6;
    rx_stall_pct = 80;
    send_byte(8'h00, 1'b0);
    send_byte(8'h40, 1'b0);
    send_byte(8'h3F, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'h7F, 1'b1);
    // The mode bit of a later byte must not matter.
    send_byte(8'hBF, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h7F, 1'b0);
    // Seventy bits give a two-word number.
    send_repeated(8'hFF, 1'b1, 9);
    send_byte(8'h7F, 1'b1);
    stop_input();
    wait_for_responses();
  endtask

  task automatic test_buffer_end();
    send_gap_pct = 80;
    rx_stall_pct = 6;
    send_repeated(8'hFF, 1'b1, 36);
    send_byte(8'h0F, 1'b1);
    send_repeated(8'hFF, 1'b1, 36);
    send_byte(8'h10, 1'b1);
    send_repeated(8'h80, 1'b1, 37);
    send_byte(8'h00, 1'b1);
    send_byte(8'hC0, 1'b0);
    send_repeated(8'hFF, 1'b0, 35);
    send_byte(8'h1F, 1'b0);
    stop_input();
    wait_for_responses();
  endtask

  task automatic test_random_traffic();
    int unsigned target;
    for (int phase = 0; phase < 3; phase++) begin
      send_gap_pct = (phase == 0) ? 6 : (phase == 1) ? 80 : 0;
      rx_stall_pct = (phase == 0) ? 80 : (phase == 1) ? 6 : 0;
      target       = bytes_sent + 12;
      while (bytes_sent < target) begin
        if ($urandom_range(99) < 15) send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
        else send_random_number();
      end
    end
  endtask

  task automatic test_backpressure();
    send_gap_pct = 0;
    rx_stall_pct = 0;
    fork
      begin
        hold_rx <= 1'b1;
        repeat (60) @(posedge clk_i);
        hold_rx <= 1'b0;
      end
      begin
        repeat (4) send_random_number();
      end
    join
    stop_input();
    wait_for_responses();
    repeat (2) send_random_number();
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    clear_accumulator();
    @(posedge clk_i);
    test_directed_values();
    test_buffer_end();
    test_random_traffic();
    test_backpressure();
    stop_input();
    wait_for_responses();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && varint_responses.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

endmodule
